@@ rtl/dhf_pkg.sv @@
`default_nettype none
package dhf_pkg;

	// divider operand widths: dividend is a full 32-bit word, divisor covers a window count of 49
	localparam int DIV_W       = 6;
	localparam int DATA_W      = 32;

	localparam logic [31:0]      ALIGN_OFFSET = 32'd1800;
	localparam logic [DIV_W-1:0] QUANT_STEP   = 6'd13;

	// floor(v / 13) == (v * QUANT_RECIP) >> QUANT_SHIFT for every 32-bit v
	localparam logic [31:0]      QUANT_RECIP  = 32'h4EC4_EC4F;
	localparam int               QUANT_SHIFT  = 34;

	// register indexes on the configuration port
	localparam logic [2:0] REG_BACKGROUND = 3'd0;
	localparam logic [2:0] REG_MIN_DEPTH  = 3'd1;
	localparam logic [2:0] REG_CUT_ROW    = 3'd2;
	localparam logic [2:0] REG_WIDTH      = 3'd3;
	localparam logic [2:0] REG_HEIGHT     = 3'd4;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CONV,
		S_SCALE,
		S_WRITE,
		S_CHECK,
		S_CENTER,
		S_WIN,
		S_MEAN,
		S_OUT
	} dhf_state_t;

	// divider handshake
	typedef struct packed {
		logic                start;
		logic [DATA_W-1:0]   dividend;
		logic [DIV_W-1:0]    divisor;
	} dhf_div_req_t;

endpackage
`default_nettype wire

@@ rtl/dhf_div.sv @@
`default_nettype none
module dhf_div
	import dhf_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire dhf_div_req_t      req,
	output logic                   done,
	output logic [DATA_W-1:0]      quotient
);

	logic [DIV_W-1:0]  rem_q;
	logic [DATA_W-1:0] quo_q;
	logic [DIV_W-1:0]  divisor_q;
	logic [5:0]        step_q;
	logic              busy_q;
	logic              done_q;
	logic [DIV_W:0]    trial;
	logic              fits;
	logic [DIV_W:0]    diff;

	// one quotient bit per cycle, restoring
	always_comb begin
		trial = {rem_q, quo_q[DATA_W-1]};
		fits  = trial >= {1'b0, divisor_q};
		diff  = trial - {1'b0, divisor_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 6'd1;
				if (step_q == 6'(DATA_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q     <= '0;
			quo_q     <= req.dividend;
			divisor_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
			quo_q <= {quo_q[DATA_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule
`default_nettype wire

@@ rtl/dhf_store.sv @@
`default_nettype none
module dhf_store
	import dhf_pkg::*;
#(
	parameter int DEPTH = 8192,
	parameter int AW    = 13
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [AW-1:0]     waddr,
	input  wire logic [DATA_W-1:0] wdata,
	input  wire logic              re,
	input  wire logic [AW-1:0]     raddr,
	output logic [DATA_W-1:0]      rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

@@ rtl/depth_requantize_hole_fill_unit.sv @@
`default_nettype none
// A result leaves after the request that completes its window: that request is converted
// (reciprocal multiply, then scale by 13) and stored, or only stored, or, as a flush, neither.
// A hole adds one store read per window pixel (up to 49) and, when the window holds any
// depth, the serial mean divide.
// Requests: one at a time, each held up further by output stalls.
// Reset: positions return to zero and registers to their defaults; the row store is not cleared.
module depth_requantize_hole_fill_unit
	import dhf_pkg::*;
#(
	parameter int MAX_WIDTH     = 1024,
	parameter int MAX_HEIGHT    = 1024,
	parameter int WINDOW_RADIUS = 3
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        operation,
	input  wire logic [7:0]  blue,
	input  wire logic [7:0]  green,
	input  wire logic [7:0]  red,
	input  wire logic [1:0]  noise,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      filled_depth,
	output logic             frame_end
);

	localparam int CW    = $clog2(MAX_WIDTH + 1);
	localparam int RW    = $clog2(MAX_HEIGHT + 1);
	localparam int RING  = 2 * WINDOW_RADIUS + 2;
	localparam int GW    = $clog2(RING);
	localparam int DEPTH = RING * MAX_WIDTH;
	localparam int AW    = $clog2(DEPTH);

	// configuration registers
	logic [31:0] bg_q;
	logic [23:0] min_q;
	logic [10:0] cut_q;
	logic [10:0] fw_q;
	logic [10:0] fh_q;

	dhf_state_t state_q, state_d;

	logic [CW-1:0] in_col_q, out_col_q;
	logic [RW-1:0] in_row_q, out_row_q;
	logic [GW-1:0] in_ring_q, out_ring_q;
	logic [1:0]    noise_q;
	logic [31:0]   value_q;
	logic [31:0]   center_q;

	// window walk
	logic [RW-1:0] win_y_q, y1_q;
	logic [CW-1:0] win_x_q, x0_q, x1_q;
	logic [GW-1:0] win_ring_q;
	logic          walk_done_q;
	logic          rd_pend_s1;
	logic [31:0]   sum_q;
	logic [DIV_W-1:0] cnt_q;

	logic          out_valid_q;
	logic [31:0]   out_data_q;
	logic          out_end_q;

	logic [CW-1:0] w_eff;
	logic [RW-1:0] h_eff;
	logic          cfg_wr;
	logic          in_accept;
	logic          slot_free;
	logic          pixel_in;
	logic [31:0]   p_in;
	logic [31:0]   conv_in;
	logic [63:0]   recip_prod;
	logic          ready;
	logic [31:0]   need_row, need_col;
	logic          last_pos;

	logic          mem_we, mem_re;
	logic [AW-1:0] mem_waddr, mem_raddr;
	logic [31:0]   mem_rdata;
	dhf_div_req_t  div_req;
	logic          div_done;
	logic [31:0]   div_q;

	// effective frame size
	always_comb begin
		if (fw_q == '0) w_eff = CW'(1);
		else if (32'(fw_q) > 32'(MAX_WIDTH)) w_eff = CW'(MAX_WIDTH);
		else w_eff = CW'(fw_q);
		if (fh_q == '0) h_eff = RW'(1);
		else if (32'(fh_q) > 32'(MAX_HEIGHT)) h_eff = RW'(MAX_HEIGHT);
		else h_eff = RW'(fh_q);
	end

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bg_q  <= 32'h00FF_FFFF;
			min_q <= '0;
			cut_q <= 11'd1024;
			fw_q  <= 11'd640;
			fh_q  <= 11'd480;
		end else if (cfg_wr) begin
			unique case (paddr[4:2])
				REG_BACKGROUND: bg_q  <= pwdata;
				REG_MIN_DEPTH:  min_q <= pwdata[23:0];
				REG_CUT_ROW:    cut_q <= pwdata[10:0];
				REG_WIDTH:      fw_q  <= pwdata[10:0];
				REG_HEIGHT:     fh_q  <= pwdata[10:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:2])
			REG_BACKGROUND: prdata = bg_q;
			REG_MIN_DEPTH:  prdata = {8'd0, min_q};
			REG_CUT_ROW:    prdata = {21'd0, cut_q};
			REG_WIDTH:      prdata = {21'd0, fw_q};
			REG_HEIGHT:     prdata = {21'd0, fh_q};
			default:        prdata = '0;
		endcase
	end

	// input decode
	assign in_accept = in_valid && !in_stall;
	assign slot_free = !out_valid_q || !out_stall;
	assign pixel_in  = !operation && (in_row_q < h_eff);
	assign p_in      = {8'd0, red, green, blue};
	assign conv_in   = ((p_in - {8'd0, min_q}) << 1) + ALIGN_OFFSET;

	// divide by the quantization step through a reciprocal multiply
	assign recip_prod = {32'd0, value_q} * {32'd0, QUANT_RECIP};

	// result readiness
	always_comb begin
		need_row = 32'(out_row_q) + 32'(WINDOW_RADIUS);
		if (need_row > 32'(h_eff) - 32'd1) need_row = 32'(h_eff) - 32'd1;
		need_col = 32'(out_col_q) + 32'(WINDOW_RADIUS);
		if (need_col > 32'(w_eff) - 32'd1) need_col = 32'(w_eff) - 32'd1;
		ready = (in_row_q >= h_eff) || (32'(in_row_q) > need_row)
			|| ((32'(in_row_q) == need_row) && (32'(in_col_q) > need_col));
		last_pos = (32'(out_col_q) + 32'd1 >= 32'(w_eff))
			&& (32'(out_row_q) + 32'd1 >= 32'(h_eff));
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_accept) begin
					priority if (!pixel_in) state_d = S_CHECK;
					else if (32'(in_row_q) >= 32'(cut_q)) state_d = S_WRITE;
					else if (p_in != bg_q) state_d = S_CONV;
					else state_d = S_WRITE;
				end
			end
			S_CONV:   state_d = S_SCALE;
			S_SCALE:  state_d = S_WRITE;
			S_WRITE:  state_d = S_CHECK;
			S_CHECK:  state_d = ready ? S_CENTER : S_IDLE;
			S_CENTER: state_d = (mem_rdata == bg_q) ? S_WIN : S_OUT;
			S_WIN: begin
				if (walk_done_q && !rd_pend_s1) state_d = (cnt_q == '0) ? S_OUT : S_MEAN;
			end
			S_MEAN:   if (div_done) state_d = S_OUT;
			S_OUT:    if (slot_free) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		in_stall         = (state_q != S_IDLE);
		mem_we           = (state_q == S_WRITE);
		mem_waddr        = AW'(32'(in_ring_q) * 32'(MAX_WIDTH) + 32'(in_col_q));
		mem_re           = 1'b0;
		mem_raddr        = AW'(32'(win_ring_q) * 32'(MAX_WIDTH) + 32'(win_x_q));
		div_req.start    = 1'b0;
		div_req.dividend = sum_q;
		div_req.divisor  = cnt_q;
		unique case (state_q)
			S_CHECK: begin
				mem_re    = ready;
				mem_raddr = AW'(32'(out_ring_q) * 32'(MAX_WIDTH) + 32'(out_col_q));
			end
			S_WIN: begin
				mem_re        = !walk_done_q;
				div_req.start = walk_done_q && !rd_pend_s1 && (cnt_q != '0);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			in_col_q    <= '0;
			in_row_q    <= '0;
			in_ring_q   <= '0;
			out_col_q   <= '0;
			out_row_q   <= '0;
			out_ring_q  <= '0;
			out_valid_q <= 1'b0;
			walk_done_q <= 1'b0;
			rd_pend_s1  <= 1'b0;
		end else begin
			state_q <= state_d;
			rd_pend_s1 <= mem_re && (state_q == S_WIN);

			// advance input position after the store write
			if (state_q == S_WRITE) begin
				if (32'(in_col_q) + 32'd1 >= 32'(w_eff)) begin
					in_col_q  <= '0;
					in_row_q  <= in_row_q + RW'(1);
					in_ring_q <= (32'(in_ring_q) == RING - 1) ? '0 : in_ring_q + GW'(1);
				end else begin
					in_col_q <= in_col_q + CW'(1);
				end
			end

			if (state_q == S_CENTER) walk_done_q <= 1'b0;

			// step the window walk
			if (state_q == S_WIN && !walk_done_q) begin
				if (win_x_q == x1_q) begin
					if (win_y_q == y1_q) begin
						walk_done_q <= 1'b1;
					end
				end
			end

			// hand over the result and advance output position, else drop an accepted one
			if (state_q == S_OUT && slot_free) begin
				out_valid_q <= 1'b1;
				if (last_pos) begin
					out_col_q  <= '0;
					out_row_q  <= '0;
					out_ring_q <= '0;
					in_col_q   <= '0;
					in_row_q   <= '0;
					in_ring_q  <= '0;
				end else if (32'(out_col_q) + 32'd1 >= 32'(w_eff)) begin
					out_col_q  <= '0;
					out_row_q  <= out_row_q + RW'(1);
					out_ring_q <= (32'(out_ring_q) == RING - 1) ? '0 : out_ring_q + GW'(1);
				end else begin
					out_col_q <= out_col_q + CW'(1);
				end
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_accept) begin
			noise_q <= noise;
			if (32'(in_row_q) >= 32'(cut_q)) value_q <= bg_q;
			else if (p_in != bg_q) value_q <= conv_in;
			else value_q <= p_in;
		end
		if (state_q == S_CONV) begin
			value_q <= 32'(recip_prod >> QUANT_SHIFT);
		end
		if (state_q == S_SCALE) begin
			value_q <= value_q * 32'(QUANT_STEP) + {30'd0, noise_q};
		end

		// set up window bounds and the ring row of the top window row
		if (state_q == S_CHECK) begin
			if (32'(out_row_q) > 32'(WINDOW_RADIUS)) begin
				win_y_q <= out_row_q - RW'(WINDOW_RADIUS);
				win_ring_q <= (32'(out_ring_q) >= 32'(WINDOW_RADIUS))
					? GW'(32'(out_ring_q) - 32'(WINDOW_RADIUS))
					: GW'(32'(out_ring_q) + 32'(RING) - 32'(WINDOW_RADIUS));
			end else begin
				win_y_q <= '0;
				win_ring_q <= (32'(out_ring_q) >= 32'(out_row_q))
					? GW'(32'(out_ring_q) - 32'(out_row_q))
					: GW'(32'(out_ring_q) + 32'(RING) - 32'(out_row_q));
			end
			y1_q <= RW'(need_row);
			x1_q <= CW'(need_col);
			if (32'(out_col_q) > 32'(WINDOW_RADIUS)) begin
				win_x_q <= out_col_q - CW'(WINDOW_RADIUS);
				x0_q    <= out_col_q - CW'(WINDOW_RADIUS);
			end else begin
				win_x_q <= '0;
				x0_q    <= '0;
			end
		end

		if (state_q == S_CENTER) begin
			center_q <= mem_rdata;
			sum_q    <= '0;
			cnt_q    <= '0;
		end

		if (state_q == S_WIN) begin
			if (!walk_done_q) begin
				if (win_x_q == x1_q) begin
					if (win_y_q != y1_q) begin
						win_x_q    <= x0_q;
						win_y_q    <= win_y_q + RW'(1);
						win_ring_q <= (32'(win_ring_q) == RING - 1) ? '0 : win_ring_q + GW'(1);
					end
				end else begin
					win_x_q <= win_x_q + CW'(1);
				end
			end
			// accumulate data of the previous read
			if (rd_pend_s1 && mem_rdata != bg_q) begin
				sum_q <= sum_q + mem_rdata;
				cnt_q <= cnt_q + DIV_W'(1);
			end
		end

		if (state_q == S_MEAN && div_done) center_q <= div_q;

		if (state_q == S_OUT && slot_free) begin
			out_data_q <= center_q;
			out_end_q  <= last_pos;
		end
	end

	assign out_valid    = out_valid_q;
	assign filled_depth = out_data_q;
	assign frame_end    = out_end_q;

	dhf_store #(
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_store (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(value_q),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	dhf_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (div_req),
		.done    (div_done),
		.quotient(div_q)
	);

endmodule
`default_nettype wire

@@ tb/tb_depth_requantize_hole_fill_unit.sv @@
`timescale 1ns / 100ps
`default_nettype none
module tb_depth_requantize_hole_fill_unit
	import dhf_pkg::*;
();

	localparam int MAX_W       = 1024;
	localparam int MAX_H       = 1024;
	localparam int RADIUS      = 3;
	localparam int RING        = 2 * RADIUS + 2;
	localparam int STALL_LIMIT = 50000;
	localparam int SETTLE      = 200;
	localparam int ITEM_TARGET = 1000;
	localparam bit OP_PIXEL    = 1'b0;
	localparam bit OP_FLUSH    = 1'b1;

	typedef struct packed {
		logic       op;
		logic [7:0] b;
		logic [7:0] g;
		logic [7:0] r;
		logic [1:0] n;
	} request_t;

	typedef struct packed {
		logic [31:0] depth;
		logic        last;
	} filled_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [4:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_stall;
	request_t    drv_req = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] filled_depth;
	logic        frame_end;

	depth_requantize_hole_fill_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall),
		.operation(drv_req.op), .blue(drv_req.b), .green(drv_req.g),
		.red(drv_req.r), .noise(drv_req.n),
		.out_valid(out_valid), .out_stall(out_stall),
		.filled_depth(filled_depth), .frame_end(frame_end)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// shadow registers and predictor state
	logic [31:0] cfg_bg = 32'hFFFFFF;
	logic [31:0] cfg_min = '0;
	int unsigned cfg_cut = 1024;
	int unsigned cfg_width = 640;
	int unsigned cfg_height = 480;
	logic [31:0] depth_ring [0:RING*MAX_W-1];
	int unsigned in_col, in_row, out_col, out_row;
	bit          frame_closed;

	request_t    pending_requests[$];
	filled_t     expected_depths[$];
	int          send_idle_pct = 0;
	int          stall_pct = 0;
	int          errors = 0;
	int          pixels_sent = 0;
	int          flushes_sent = 0;
	int          depths_checked = 0;
	int          frames_done = 0;
	int          quiet_cycles = 0;

	// append a request behind the pending ones
	function automatic void enqueue(request_t rq);
		pending_requests.insert(pending_requests.size(), rq);
	endfunction

	function automatic int unsigned eff_size(int unsigned v, int unsigned maxv);
		if (v == 0) return 1;
		return (v > maxv) ? maxv : v;
	endfunction

	function automatic int unsigned umin(int unsigned a, int unsigned b);
		return (a < b) ? a : b;
	endfunction

	function automatic logic [31:0] ring_cell(int unsigned row, int unsigned col);
		return depth_ring[(row % RING) * MAX_W + col];
	endfunction

	// convert, store, and emit the next hole-filled depth once its window is complete
	function automatic void predict_fill(request_t rq);
		int unsigned w, h, need_row, need_col, y, x, y0, y1, x0, x1, cnt;
		logic [31:0] p, v, center, sum;
		bit          ready, last;
		w = eff_size(cfg_width, MAX_W);
		h = eff_size(cfg_height, MAX_H);
		if (rq.op == OP_PIXEL && in_row < h) begin
			p = {8'h00, rq.r, rq.g, rq.b};
			if (in_row >= cfg_cut) begin
				v = cfg_bg;
			end else if (p != cfg_bg) begin
				v = (p - cfg_min) * 32'd2 + ALIGN_OFFSET;
				v = (v / 32'(QUANT_STEP)) * 32'(QUANT_STEP) + 32'(rq.n);
			end else begin
				v = p;
			end
			depth_ring[(in_row % RING) * MAX_W + in_col] = v;
			in_col++;
			if (in_col >= w) begin
				in_col = 0;
				in_row++;
			end
		end
		need_row = umin(out_row + RADIUS, h - 1);
		need_col = umin(out_col + RADIUS, w - 1);
		ready = (in_row >= h) || (in_row > need_row) ||
			(in_row == need_row && in_col > need_col);
		if (!ready) return;
		center = ring_cell(out_row, out_col);
		if (center == cfg_bg) begin
			sum = '0;
			cnt = 0;
			y0 = (out_row > RADIUS) ? out_row - RADIUS : 0;
			y1 = umin(out_row + RADIUS, h - 1);
			x0 = (out_col > RADIUS) ? out_col - RADIUS : 0;
			x1 = umin(out_col + RADIUS, w - 1);
			for (y = y0; y <= y1; y++)
				for (x = x0; x <= x1; x++)
					if (ring_cell(y, x) != cfg_bg) begin
						sum += ring_cell(y, x);
						cnt++;
					end
			if (cnt != 0) center = sum / cnt;
		end
		last = 1'b0;
		out_col++;
		if (out_col >= w) begin
			out_col = 0;
			out_row++;
			if (out_row >= h) last = 1'b1;
		end
		if (last) begin
			out_row = 0;
			out_col = 0;
			in_row = 0;
			in_col = 0;
			frame_closed = 1'b1;
		end
		expected_depths.insert(expected_depths.size(), '{depth: center, last: last});
	endfunction

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		errors++;
	endtask

	// request driver: predict on acceptance, then load the next request or idle
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				predict_fill(drv_req);
				if (drv_req.op == OP_PIXEL) pixels_sent++;
				else flushes_sent++;
			end
			if (!in_valid || !in_stall) begin
				if (pending_requests.size() != 0 &&
						$urandom_range(0, 99) >= send_idle_pct) begin
					drv_req <= pending_requests.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor and random stall
	always @(posedge clk) begin
		out_stall <= ($urandom_range(0, 99) < stall_pct);
		if (arst_n && out_valid && !out_stall) begin
			if (expected_depths.size() == 0) begin
				report_mismatch($sformatf("unexpected depth %h", filled_depth));
			end else begin
				filled_t e;
				e = expected_depths.pop_front();
				depths_checked++;
				if (filled_depth !== e.depth)
					report_mismatch($sformatf("filled_depth %h, want %h",
						filled_depth, e.depth));
				if (frame_end !== e.last)
					report_mismatch($sformatf("frame_end %b, want %b", frame_end, e.last));
				if (e.last) frames_done++;
			end
		end
	end

	// watchdog on handshake activity
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic reg_write(input logic [2:0] idx, input logic [31:0] d);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= d;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_BACKGROUND: cfg_bg = d;
			REG_MIN_DEPTH:  cfg_min = {8'h00, d[23:0]};
			REG_CUT_ROW:    cfg_cut = {21'd0, d[10:0]};
			REG_WIDTH:      cfg_width = {21'd0, d[10:0]};
			REG_HEIGHT:     cfg_height = {21'd0, d[10:0]};
			default: ;
		endcase
	endtask

	task automatic wait_sender_idle();
		while (pending_requests.size() != 0 || in_valid) begin
			@(posedge clk);
			#1;
		end
	endtask

	// hold until every request is in and every depth is out, then let the pipe settle
	task automatic drain();
		wait_sender_idle();
		while (expected_depths.size() != 0) begin
			@(posedge clk);
			#1;
		end
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic configure(input logic [31:0] bg, input logic [31:0] mn,
			input logic [31:0] cut, input logic [31:0] w, input logic [31:0] h);
		drain();
		reg_write(REG_BACKGROUND, bg);
		reg_write(REG_MIN_DEPTH, mn);
		reg_write(REG_CUT_ROW, cut);
		reg_write(REG_WIDTH, w);
		reg_write(REG_HEIGHT, h);
	endtask

	function automatic request_t make_pixel(logic [23:0] p, logic [1:0] n);
		return '{op: OP_PIXEL, b: p[7:0], g: p[15:8], r: p[23:16], n: n};
	endfunction

	function automatic request_t random_pixel(int hole_pct);
		logic [23:0] p;
		p = 24'($urandom());
		if ($urandom_range(0, 99) < hole_pct) p = cfg_bg[23:0];
		return make_pixel(p, 2'($urandom_range(0, 3)));
	endfunction

	// flush out the rest of the frame; stray pixels here are dropped by the block
	task automatic close_frame();
		request_t rq;
		wait_sender_idle();
		while (!frame_closed) begin
			rq = random_pixel(0);
			if ($urandom_range(0, 99) < 80) rq.op = OP_FLUSH;
			enqueue(rq);
			wait_sender_idle();
		end
	endtask

	task automatic random_frame(int hole_pct);
		int unsigned n;
		request_t    rq;
		frame_closed = 1'b0;
		n = eff_size(cfg_width, MAX_W) * eff_size(cfg_height, MAX_H);
		for (int unsigned i = 0; i < n; i++) begin
			if ($urandom_range(0, 99) < 4) begin
				rq = random_pixel(0);
				rq.op = OP_FLUSH;
				enqueue(rq);
			end
			enqueue(random_pixel(hole_pct));
		end
		close_frame();
	endtask

	task automatic set_idling(int mode);
		case (mode % 4)
			0: begin send_idle_pct = 0;  stall_pct = 0;  end
			1: begin send_idle_pct = 47; stall_pct = 0;  end
			2: begin send_idle_pct = 0;  stall_pct = 47; end
			default: begin send_idle_pct = 19; stall_pct = 19; end
		endcase
	endtask

	initial begin
		logic [31:0] bg, mn;
		int          phase;
		in_col = 0; in_row = 0; out_col = 0; out_row = 0;
		frame_closed = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extreme depths, holes, flush with nothing ready, noise of 3
		configure(32'hFFFFFF, 32'h0, 32'd1024, 32'd3, 32'd3);
		frame_closed = 1'b0;
		enqueue('{op: OP_FLUSH, b: 8'h00, g: 8'h00, r: 8'h00, n: 2'd0});
		enqueue(make_pixel(24'h000000, 2'd0));
		enqueue(make_pixel(24'hFFFFFF, 2'd1));
		enqueue(make_pixel(24'hFFFFFE, 2'd2));
		enqueue(make_pixel(24'hFFFFFF, 2'd3));
		enqueue(make_pixel(24'h010203, 2'd0));
		enqueue(make_pixel(24'hFFFFFF, 2'd3));
		enqueue(make_pixel(24'h800000, 2'd2));
		enqueue(make_pixel(24'hFFFFFF, 2'd1));
		enqueue(make_pixel(24'h00FF00, 2'd3));
		close_frame();

		// directed: converted value landing on the background code, large offset
		configure(32'd2302, 32'h0, 32'd1024, 32'd2, 32'd2);
		frame_closed = 1'b0;
		enqueue(make_pixel(24'h000100, 2'd1));
		enqueue(make_pixel(24'h0008FE, 2'd0));
		enqueue(make_pixel(24'h000101, 2'd2));
		enqueue(make_pixel(24'h000100, 2'd1));
		close_frame();

		// directed: zero sizes act as one, whole frame cut to background
		configure(32'hFFFFFFFF, 32'hFFFFFF, 32'd0, 32'd0, 32'd0);
		frame_closed = 1'b0;
		enqueue(make_pixel(24'h123456, 2'd2));
		close_frame();

		// directed: cut from row one, background zero
		configure(32'h0, 32'h000010, 32'd1, 32'd3, 32'd2);
		frame_closed = 1'b0;
		for (int i = 0; i < 6; i++)
			enqueue(make_pixel((i % 2) ? 24'h0 : 24'hFFFFFF, 2'(i)));
		close_frame();

		// random phases over small frames
		phase = 0;
		while (pixels_sent + flushes_sent < ITEM_TARGET) begin
			set_idling(phase);
			case ($urandom_range(0, 4))
				0: bg = 32'hFFFFFF;
				1: bg = 32'h0;
				2: bg = 32'hFFFFFFFF;
				3: bg = $urandom();
				default: bg = {8'h00, 24'($urandom())};
			endcase
			case ($urandom_range(0, 3))
				0: mn = 32'h0;
				1: mn = 32'hFFFFFF;
				default: mn = $urandom();
			endcase
			configure(bg, mn,
				($urandom_range(0, 5) == 0) ? 32'd2047 : $urandom_range(0, 12),
				($urandom_range(0, 9) == 0) ? 32'd0 : $urandom_range(1, 12),
				($urandom_range(0, 9) == 0) ? 32'd0 : $urandom_range(1, 10));
			repeat ($urandom_range(1, 3)) random_frame($urandom_range(10, 60));
			phase++;
		end

		drain();
		$display("covered %0d pixels, %0d flushes, %0d frames over %0d random phases",
			pixels_sent, flushes_sent, frames_done, phase);
		$display("checked %0d filled depths under four idling patterns", depths_checked);
		if (errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
`default_nettype wire
